FILE: hdl/trajectory_moving_average_stabilizer_defines.svh
// Shared assertion macros. Each one expects i_clk and i_rst_n in the module that uses it.
`ifndef TRAJECTORY_MOVING_AVERAGE_STABILIZER_DEFINES_SVH
`define TRAJECTORY_MOVING_AVERAGE_STABILIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tmas_pkg.sv
package tmas_pkg;

    // The window length is 2^DigW - 1, so the mean divider works in base 2^DigW.
    localparam int DigW      = 5;
    localparam int WinLen    = (1 << DigW) - 1;
    localparam int WinExtra  = WinLen - 1;
    localparam int RoundBias = WinLen / 2;
    localparam int PtrW      = $clog2(WinLen);

    localparam int NAxis  = 3;
    localparam int InW    = 32;
    localparam int PosW   = 48;
    localparam int SumW   = 54;
    localparam int FrameW = 32;

    localparam int NDig   = (SumW + DigW - 1) / DigW;
    localparam int NDigHi = (NDig + 1) / 2;
    localparam int NDigLo = NDig - NDigHi;
    localparam int MagW   = NDig * DigW;

    localparam int SDataW = NAxis * InW;
    localparam int MDataW = 5 * PosW + FrameW;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [PtrW-1:0] LastSlot = PtrW'(WinLen - 1);
    localparam logic [PosW-1:0] PosMax   = {1'b0, {(PosW - 1){1'b1}}};
    localparam logic [PosW-1:0] PosMin   = {1'b1, {(PosW - 1){1'b0}}};

    typedef struct packed {
        logic [NAxis-1:0][SumW-1:0] sum;
        logic [NAxis-1:0][PosW-1:0] old;
        logic [FrameW-1:0]          frame;
    } t_qent;

    typedef struct packed {
        logic             empty;
        logic [QCntW-1:0] count;
    } t_qstat;

    function automatic logic [PosW-1:0] f_sat_pos(input logic [PosW+1:0] v);
        logic [2:0] top;
        top = v[PosW+1:PosW-1];
        if (top == 3'b000 || top == 3'b111) begin
            return v[PosW-1:0];
        end else if (v[PosW+1]) begin
            return PosMin;
        end else begin
            return PosMax;
        end
    endfunction

    function automatic logic [PtrW-1:0] f_slot_inc(input logic [PtrW-1:0] p);
        return (p == LastSlot) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: hdl/tmas_ram.sv
module tmas_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tmas_front.sv
`include "trajectory_moving_average_stabilizer_defines.svh"

module tmas_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tmas_pkg::SDataW-1:0]   i_data,
    input  tmas_pkg::t_qstat              i_qstat,
    output logic                          o_push,
    output tmas_pkg::t_qent               o_push_ent
);

    logic                                    w_accept;
    logic                                    w_out;
    logic [tmas_pkg::QCntW:0]                w_used;
    logic [tmas_pkg::PtrW-1:0]               r_fill;
    logic [tmas_pkg::PtrW-1:0]               r_wptr;
    logic [tmas_pkg::PtrW-1:0]               r_rptr;
    logic                                    r_zero0;
    logic [tmas_pkg::FrameW-1:0]             r_frame;
    logic [tmas_pkg::PosW-1:0]               r_cum     [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]               n_cum     [tmas_pkg::NAxis];
    logic [tmas_pkg::SumW-1:0]               r_sum     [tmas_pkg::NAxis];
    logic [tmas_pkg::SumW-1:0]               n_sum     [tmas_pkg::NAxis];
    logic [tmas_pkg::SumW-1:0]               w_sum_pre [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]               w_old     [tmas_pkg::NAxis];
    logic                                    r_f1_valid;
    logic                                    r_f1_out;
    logic                                    r_f1_zero;
    logic [tmas_pkg::PosW-1:0]               r_f1_cum  [tmas_pkg::NAxis];
    logic [tmas_pkg::FrameW-1:0]             r_f1_frame;
    logic [tmas_pkg::NAxis*tmas_pkg::PosW-1:0] w_wdata;
    logic [tmas_pkg::NAxis*tmas_pkg::PosW-1:0] w_rdata;

    // Reserve a queue entry for the window result that is still one stage away.
    assign w_used   = {1'b0, i_qstat.count} + {{tmas_pkg::QCntW{1'b0}}, r_f1_valid & r_f1_out};
    assign o_ready  = w_used < (tmas_pkg::QCntW + 1)'(tmas_pkg::QDepth);
    assign w_accept = i_valid && o_ready;
    assign w_out    = r_fill == tmas_pkg::PtrW'(tmas_pkg::WinExtra);

    always_comb begin
        for (int k = 0; k < tmas_pkg::NAxis; k++) begin
            n_cum[k] = tmas_pkg::f_sat_pos(
                {{2{r_cum[k][tmas_pkg::PosW-1]}}, r_cum[k]} +
                {{(tmas_pkg::PosW + 2 - tmas_pkg::InW){i_data[k*tmas_pkg::InW+tmas_pkg::InW-1]}},
                 i_data[k*tmas_pkg::InW +: tmas_pkg::InW]});
            w_wdata[k*tmas_pkg::PosW +: tmas_pkg::PosW] = n_cum[k];
        end
    end

    tmas_ram #(
        .Width(tmas_pkg::NAxis * tmas_pkg::PosW),
        .Depth(tmas_pkg::WinLen)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wptr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (r_rptr),
        .o_rdata (w_rdata)
    );

    // The initial window entry is zero and lives in a slot that was never written.
    always_comb begin
        for (int k = 0; k < tmas_pkg::NAxis; k++) begin
            w_old[k]     = r_f1_zero ? '0 : w_rdata[k*tmas_pkg::PosW +: tmas_pkg::PosW];
            w_sum_pre[k] = r_sum[k] +
                {{(tmas_pkg::SumW - tmas_pkg::PosW){r_f1_cum[k][tmas_pkg::PosW-1]}}, r_f1_cum[k]};
            n_sum[k]     = r_f1_out ?
                w_sum_pre[k] -
                {{(tmas_pkg::SumW - tmas_pkg::PosW){w_old[k][tmas_pkg::PosW-1]}}, w_old[k]} :
                w_sum_pre[k];
            o_push_ent.sum[k] = w_sum_pre[k];
            o_push_ent.old[k] = w_old[k];
        end
        o_push_ent.frame = r_f1_frame;
    end

    assign o_push = r_f1_valid & r_f1_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= tmas_pkg::PtrW'(1);
            r_wptr     <= tmas_pkg::PtrW'(1);
            r_rptr     <= '0;
            r_zero0    <= 1'b1;
            r_frame    <= '0;
            r_f1_valid <= 1'b0;
            r_f1_out   <= 1'b0;
            for (int k = 0; k < tmas_pkg::NAxis; k++) begin
                r_cum[k] <= '0;
                r_sum[k] <= '0;
            end
        end else begin
            r_f1_valid <= w_accept;
            r_f1_out   <= w_accept & w_out;
            if (w_accept) begin
                r_wptr <= tmas_pkg::f_slot_inc(r_wptr);
                for (int k = 0; k < tmas_pkg::NAxis; k++) begin
                    r_cum[k] <= n_cum[k];
                end
                if (w_out) begin
                    r_rptr  <= tmas_pkg::f_slot_inc(r_rptr);
                    r_frame <= r_frame + 1'b1;
                    r_zero0 <= 1'b0;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_f1_valid) begin
                for (int k = 0; k < tmas_pkg::NAxis; k++) begin
                    r_sum[k] <= n_sum[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_zero  <= r_zero0;
            r_f1_frame <= r_frame;
            r_f1_cum   <= n_cum;
        end
    end

    `TMAS_ASSERT_NOW(a_warmup_ptrs, r_fill != tmas_pkg::PtrW'(tmas_pkg::WinExtra), r_wptr == r_fill && r_rptr == '0, "window pointers drifted during warm-up")
    `TMAS_ASSERT_NOW(a_full_ptrs, r_fill == tmas_pkg::PtrW'(tmas_pkg::WinExtra), r_rptr == tmas_pkg::f_slot_inc(r_wptr), "oldest slot does not follow the write slot")

endmodule

FILE: hdl/tmas_queue.sv
`include "trajectory_moving_average_stabilizer_defines.svh"

module tmas_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tmas_pkg::t_qent  i_push_ent,
    input  logic             i_pop,
    output tmas_pkg::t_qent  o_ent,
    output tmas_pkg::t_qstat o_stat
);

    tmas_pkg::t_qent            r_ent [tmas_pkg::QDepth];
    logic [tmas_pkg::QPtrW-1:0] r_wp;
    logic [tmas_pkg::QPtrW-1:0] r_rp;
    logic [tmas_pkg::QCntW-1:0] r_cnt;

    function automatic logic [tmas_pkg::QPtrW-1:0] f_qinc(input logic [tmas_pkg::QPtrW-1:0] p);
        return (p == tmas_pkg::QPtrW'(tmas_pkg::QDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= f_qinc(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_qinc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_push_ent;
        end
    end

    assign o_ent        = r_ent[r_rp];
    assign o_stat.empty = r_cnt == '0;
    assign o_stat.count = r_cnt;

    `TMAS_ASSERT_NOW(a_no_overflow, i_push, r_cnt < tmas_pkg::QCntW'(tmas_pkg::QDepth), "push into a full queue")
    `TMAS_ASSERT_NOW(a_no_underflow, i_pop, r_cnt != '0, "pop from an empty queue")
    `TMAS_ASSERT_NEXT(a_count_pop, i_pop && !i_push, r_cnt == $past(r_cnt) - 1'b1, "queue count did not drop on pop")

endmodule

FILE: hdl/tmas_back.sv
module tmas_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tmas_pkg::t_qstat            i_qstat,
    input  tmas_pkg::t_qent             i_ent,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tmas_pkg::MDataW-1:0] o_data
);

    logic                                      w_adv;
    logic                                      r_s1_v;
    logic                                      r_s2_v;
    logic                                      r_s3_v;
    logic                                      r_ov;
    logic [tmas_pkg::NAxis-1:0]                r_s1_neg;
    logic [tmas_pkg::NAxis-1:0]                r_s2_neg;
    logic [tmas_pkg::NAxis-1:0]                r_s3_neg;
    logic [tmas_pkg::MagW-1:0]                 w_mag     [tmas_pkg::NAxis];
    logic [tmas_pkg::MagW-1:0]                 r_s1_mag  [tmas_pkg::NAxis];
    logic [tmas_pkg::DigW-1:0]                 w_rem_hi  [tmas_pkg::NAxis];
    logic [tmas_pkg::DigW-1:0]                 r_s2_rem  [tmas_pkg::NAxis];
    logic [tmas_pkg::NDigHi*tmas_pkg::DigW-1:0] w_qhi    [tmas_pkg::NAxis];
    logic [tmas_pkg::NDigHi*tmas_pkg::DigW-1:0] r_s2_qhi [tmas_pkg::NAxis];
    logic [tmas_pkg::NDigLo*tmas_pkg::DigW-1:0] r_s2_lo  [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]                 w_q       [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]                 r_s3_q    [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]                 r_s1_old  [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]                 r_s2_old  [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]                 r_s3_old  [tmas_pkg::NAxis];
    logic [tmas_pkg::FrameW-1:0]               r_s1_frame;
    logic [tmas_pkg::FrameW-1:0]               r_s2_frame;
    logic [tmas_pkg::FrameW-1:0]               r_s3_frame;
    logic [tmas_pkg::PosW-1:0]                 w_corr    [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]                 w_smooth;
    logic [tmas_pkg::PosW-1:0]                 r_corr    [tmas_pkg::NAxis];
    logic [tmas_pkg::PosW-1:0]                 r_raw;
    logic [tmas_pkg::PosW-1:0]                 r_smooth;
    logic [tmas_pkg::FrameW-1:0]               r_frame;

    // One base-2^DigW digit of long division by 2^DigW - 1; returns quotient digit and remainder.
    function automatic logic [2*tmas_pkg::DigW-1:0] f_dig_step(
        input logic [tmas_pkg::DigW-1:0] rem,
        input logic [tmas_pkg::DigW-1:0] dig
    );
        logic [tmas_pkg::DigW:0] t;
        logic                    c;
        t = {1'b0, rem} + {1'b0, dig};
        c = t >= (tmas_pkg::DigW + 1)'(tmas_pkg::WinLen);
        return {rem + tmas_pkg::DigW'(c),
                c ? tmas_pkg::DigW'(t - (tmas_pkg::DigW + 1)'(tmas_pkg::WinLen))
                  : t[tmas_pkg::DigW-1:0]};
    endfunction

    assign w_adv   = !r_ov || i_ready;
    assign o_pop   = w_adv && !i_qstat.empty;
    assign o_valid = r_ov;

    // Magnitude plus half the divisor gives rounding with ties away from zero.
    always_comb begin
        for (int k = 0; k < tmas_pkg::NAxis; k++) begin
            if (i_ent.sum[k][tmas_pkg::SumW-1]) begin
                w_mag[k] = {{(tmas_pkg::MagW - tmas_pkg::SumW){1'b0}}, ~i_ent.sum[k]} +
                           tmas_pkg::MagW'(tmas_pkg::RoundBias + 1);
            end else begin
                w_mag[k] = {{(tmas_pkg::MagW - tmas_pkg::SumW){1'b0}}, i_ent.sum[k]} +
                           tmas_pkg::MagW'(tmas_pkg::RoundBias);
            end
        end
    end

    always_comb begin
        logic [tmas_pkg::DigW-1:0]   v_rem;
        logic [2*tmas_pkg::DigW-1:0] v_st;
        for (int k = 0; k < tmas_pkg::NAxis; k++) begin
            v_rem = '0;
            for (int d = 0; d < tmas_pkg::NDigHi; d++) begin
                v_st = f_dig_step(v_rem,
                    r_s1_mag[k][tmas_pkg::MagW-1-d*tmas_pkg::DigW -: tmas_pkg::DigW]);
                w_qhi[k][(tmas_pkg::NDigHi-1-d)*tmas_pkg::DigW +: tmas_pkg::DigW] =
                    v_st[2*tmas_pkg::DigW-1:tmas_pkg::DigW];
                v_rem = v_st[tmas_pkg::DigW-1:0];
            end
            w_rem_hi[k] = v_rem;
        end
    end

    always_comb begin
        logic [tmas_pkg::DigW-1:0]                  v_rem;
        logic [2*tmas_pkg::DigW-1:0]                v_st;
        logic [tmas_pkg::NDigLo*tmas_pkg::DigW-1:0] v_qlo;
        logic [tmas_pkg::MagW-1:0]                  v_full;
        for (int k = 0; k < tmas_pkg::NAxis; k++) begin
            v_rem = r_s2_rem[k];
            for (int d = 0; d < tmas_pkg::NDigLo; d++) begin
                v_st = f_dig_step(v_rem,
                    r_s2_lo[k][(tmas_pkg::NDigLo-1-d)*tmas_pkg::DigW +: tmas_pkg::DigW]);
                v_qlo[(tmas_pkg::NDigLo-1-d)*tmas_pkg::DigW +: tmas_pkg::DigW] =
                    v_st[2*tmas_pkg::DigW-1:tmas_pkg::DigW];
                v_rem = v_st[tmas_pkg::DigW-1:0];
            end
            v_full = {r_s2_qhi[k], v_qlo};
            w_q[k] = v_full[tmas_pkg::PosW-1:0];
        end
    end

    // A negative mean turns oldest minus mean into oldest plus magnitude.
    always_comb begin
        for (int k = 0; k < tmas_pkg::NAxis; k++) begin
            if (r_s3_neg[k]) begin
                w_corr[k] = tmas_pkg::f_sat_pos(
                    {{2{r_s3_old[k][tmas_pkg::PosW-1]}}, r_s3_old[k]} + {2'b00, r_s3_q[k]});
            end else begin
                w_corr[k] = tmas_pkg::f_sat_pos(
                    {{2{r_s3_old[k][tmas_pkg::PosW-1]}}, r_s3_old[k]} - {2'b00, r_s3_q[k]});
            end
        end
        w_smooth = r_s3_neg[0] ? ~r_s3_q[0] + 1'b1 : r_s3_q[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= o_pop;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_ov   <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < tmas_pkg::NAxis; k++) begin
                r_s1_neg[k] <= i_ent.sum[k][tmas_pkg::SumW-1];
                r_s1_mag[k] <= w_mag[k];
                r_s1_old[k] <= i_ent.old[k];
                r_s2_neg[k] <= r_s1_neg[k];
                r_s2_rem[k] <= w_rem_hi[k];
                r_s2_qhi[k] <= w_qhi[k];
                r_s2_lo[k]  <= r_s1_mag[k][tmas_pkg::NDigLo*tmas_pkg::DigW-1:0];
                r_s2_old[k] <= r_s1_old[k];
                r_s3_neg[k] <= r_s2_neg[k];
                r_s3_q[k]   <= w_q[k];
                r_s3_old[k] <= r_s2_old[k];
                r_corr[k]   <= w_corr[k];
            end
            r_s1_frame <= i_ent.frame;
            r_s2_frame <= r_s1_frame;
            r_s3_frame <= r_s2_frame;
            r_raw      <= r_s3_old[0];
            r_smooth   <= w_smooth;
            r_frame    <= r_s3_frame;
        end
    end

    assign o_data = {r_frame, r_smooth, r_raw, r_corr[2], r_corr[1], r_corr[0]};

endmodule

FILE: hdl/trajectory_moving_average_stabilizer.sv
// Channel  Direction  Beat contents, low bits first
// s_*      input      motion_x, motion_y, motion_angle (32 bits each)
// m_*      output     corr_x, corr_y, corr_angle, raw_pos_x, smooth_pos_x (48 each), frame_index (32)
//
// One beat is accepted per cycle while s_tready is high; the trajectory and window sum registers update once per beat.
// A result passes from its input beat through a four-entry queue and a
// three-stage divide-by-31 pipeline. The first 29 beats after reset only fill the window.
// s_tready falls when the queue, counting a result one stage away, is full; m_tready low
// while m_tvalid is high stalls the whole back pipeline. Synchronous reset empties the window at once.
module trajectory_moving_average_stabilizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tmas_pkg::SDataW-1:0] s_tdata,  // motion_x, motion_y, motion_angle
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tmas_pkg::MDataW-1:0] m_tdata   // corr_x, corr_y, corr_angle, raw_pos_x,
                                                   // smooth_pos_x, frame_index
);

    logic             w_push;
    tmas_pkg::t_qent  w_push_ent;
    logic             w_pop;
    tmas_pkg::t_qent  w_qent;
    tmas_pkg::t_qstat w_qstat;

    tmas_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_data     (s_tdata),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_push_ent (w_push_ent)
    );

    tmas_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_ent (w_push_ent),
        .i_pop      (w_pop),
        .o_ent      (w_qent),
        .o_stat     (w_qstat)
    );

    tmas_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .i_ent   (w_qent),
        .o_pop   (w_pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata)
    );

endmodule
